[rtl/sftr_pkg.sv]
`default_nettype none
package sftr_pkg;

    // Field widths
    localparam int TICK_W   = 32;
    localparam int STEP_W   = 12;
    localparam int RATIO_W  = 17;
    localparam int OFFS_W   = 16;
    localparam int DATA_W   = 48;
    localparam int WORD_W   = 16;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int S_TDATA_W = 112;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 96;
    localparam int M_TUSER_W = 1;
    localparam int DIV_CNT_W = 5;

    // Host tick scaling: ticks * 625 / 64 into 25us units
    localparam int SCALE_MUL   = 625;
    localparam int SCALE_SHIFT = 6;
    localparam int FRAC_PROD_W = 16;

    // Register reset values
    localparam logic [STEP_W-1:0]  STEP_RST      = 12'd96;
    localparam logic [TICK_W-1:0]  MAX_INTV_RST  = 32'd65535;
    localparam logic [RATIO_W-1:0] RATIO_MIN_RST = 17'd55705;
    localparam logic [RATIO_W-1:0] RATIO_MAX_RST = 17'd75366;
    localparam logic [RATIO_W-1:0] RATIO_UNITY   = 17'd65536;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STAMP_STEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAIR_MAX_INT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_MIN    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_MAX    = 2'd3;

    // Item command codes
    localparam logic CMD_PAIR  = 1'b0;
    localparam logic CMD_ENTRY = 1'b1;

    // FIFO entry kinds
    localparam logic [1:0] KIND_TIMESTAMP = 2'd0;
    localparam logic [1:0] KIND_ACCEL     = 2'd1;
    localparam logic [1:0] KIND_TEMP      = 2'd2;
    localparam logic [1:0] KIND_OTHER     = 2'd3;

    // Result sample kinds
    localparam logic SAMPLE_MOTION = 1'b0;
    localparam logic SAMPLE_TEMP   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PAIR_CHECK,
        ST_DIV,
        ST_DIV_DONE,
        ST_STAMP_DIFF,
        ST_STAMP_SCALE,
        ST_STAMP_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic pair_scale;
        logic div_start;
        logic div_step;
        logic ratio_update;
        logic pair_store;
        logic set_anchor;
        logic stamp_add;
        logic stamp_diff;
        logic stamp_scale;
        logic out_load;
        logic offset_inc;
    } dp_cmd_t;

    typedef struct packed {
        logic       is_pair;
        logic [1:0] kind;
        logic       anchor_valid;
        logic       div_ok;
        logic       div_last;
    } dp_sts_t;

endpackage
`default_nettype wire

[rtl/sftr_dp.sv]
`default_nettype none
module sftr_dp
    import sftr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    input  wire dp_cmd_t               cmd,
    output dp_sts_t                    sts,
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic [M_TUSER_W-1:0]       m_tuser
);

    // Configuration
    logic [STEP_W-1:0]  step_reg;
    logic [TICK_W-1:0]  max_intv_reg;
    logic [RATIO_W-1:0] ratio_min_reg;
    logic [RATIO_W-1:0] ratio_max_reg;

    // Architectural state
    logic [TICK_W-1:0]  pair_host_reg;
    logic [TICK_W-1:0]  pair_dev_reg;
    logic               pair_valid_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic [TICK_W-1:0]  anchor_reg;
    logic [OFFS_W-1:0]  offset_reg;
    logic               anchor_valid_reg;

    // Captured item
    logic               cmd_in_reg;
    logic [TICK_W-1:0]  host_in_reg;
    logic [TICK_W-1:0]  dev_in_reg;
    logic [1:0]         kind_in_reg;
    logic [DATA_W-1:0]  data_in_reg;

    // Working registers
    logic [TICK_W-1:0]         host_scaled_reg;
    logic [OFFS_W+STEP_W-1:0]  prod_reg;
    logic [TICK_W-1:0]         devst_reg;
    logic [TICK_W-1:0]         mag_reg;
    logic                      neg_reg;
    logic [WORD_W-1:0]         part_reg;
    logic [TICK_W-1:0]         rem_reg;
    logic [TICK_W-1:0]         quo_reg;
    logic [TICK_W-1:0]         dvs_reg;
    logic [DIV_CNT_W-1:0]      cnt_reg;

    // Output register
    logic               out_kind_reg;
    logic [TICK_W-1:0]  out_stamp_reg;
    logic [WORD_W-1:0]  out_x_reg;
    logic [WORD_W-1:0]  out_y_reg;
    logic [WORD_W-1:0]  out_z_reg;
    logic [WORD_W-1:0]  out_t_reg;

    logic [TICK_W-1:0]      scale_hi;
    logic [FRAC_PROD_W-1:0] scale_lo;
    logic [TICK_W-1:0]      host_scaled_next;
    logic [TICK_W-1:0]      dh;
    logic [TICK_W-1:0]      dd;
    logic [TICK_W:0]        div_trial;
    logic                   div_bit;
    logic                   ratio_in_clamp;
    logic [TICK_W-1:0]      diff;
    logic [TICK_W+RATIO_W-1:0] scaled_prod;
    logic [TICK_W-1:0]      stamp_next;

    // ticks*625/64 split so the low bits keep their fraction
    assign scale_hi = TICK_W'(host_in_reg[TICK_W-1:SCALE_SHIFT]) * TICK_W'(SCALE_MUL);
    assign scale_lo = FRAC_PROD_W'(host_in_reg[SCALE_SHIFT-1:0]) * FRAC_PROD_W'(SCALE_MUL);
    assign host_scaled_next = scale_hi + TICK_W'(scale_lo[FRAC_PROD_W-1:SCALE_SHIFT]);

    assign dh = host_scaled_reg - pair_host_reg;
    assign dd = dev_in_reg - pair_dev_reg;

    // restoring divide, one quotient bit per cycle
    assign div_trial = {rem_reg, quo_reg[TICK_W-1]};
    assign div_bit   = (div_trial >= {1'b0, dvs_reg});

    assign ratio_in_clamp = (quo_reg >= TICK_W'(ratio_min_reg)) &&
                            (quo_reg <= TICK_W'(ratio_max_reg));

    assign diff        = pair_dev_reg - devst_reg;
    assign scaled_prod = mag_reg * ratio_reg;
    assign stamp_next  = neg_reg ? pair_host_reg + TICK_W'(part_reg)
                                 : pair_host_reg - TICK_W'(part_reg);

    assign sts.is_pair      = (cmd_in_reg == CMD_PAIR);
    assign sts.kind         = kind_in_reg;
    assign sts.anchor_valid = anchor_valid_reg;
    assign sts.div_ok       = pair_valid_reg && (dd != '0) && (dh <= max_intv_reg);
    assign sts.div_last     = (cnt_reg == '1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= STEP_RST;
            max_intv_reg     <= MAX_INTV_RST;
            ratio_min_reg    <= RATIO_MIN_RST;
            ratio_max_reg    <= RATIO_MAX_RST;
            pair_host_reg    <= '0;
            pair_dev_reg     <= '0;
            pair_valid_reg   <= 1'b0;
            ratio_reg        <= RATIO_UNITY;
            anchor_reg       <= '0;
            offset_reg       <= '0;
            anchor_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_STAMP_STEP:   step_reg      <= cfg_data[STEP_W-1:0];
                    CFG_PAIR_MAX_INT: max_intv_reg  <= cfg_data[TICK_W-1:0];
                    CFG_RATIO_MIN:    ratio_min_reg <= cfg_data[RATIO_W-1:0];
                    CFG_RATIO_MAX:    ratio_max_reg <= cfg_data[RATIO_W-1:0];
                    default:          step_reg      <= step_reg;
                endcase
            end
            if (cmd.ratio_update && ratio_in_clamp)
            begin
                ratio_reg <= quo_reg[RATIO_W-1:0];
            end
            if (cmd.pair_store)
            begin
                pair_host_reg  <= host_scaled_reg;
                pair_dev_reg   <= dev_in_reg;
                pair_valid_reg <= 1'b1;
            end
            if (cmd.set_anchor)
            begin
                anchor_reg       <= data_in_reg[TICK_W-1:0];
                offset_reg       <= '0;
                anchor_valid_reg <= 1'b1;
            end
            else if (cmd.offset_inc)
            begin
                offset_reg <= offset_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        // offset holds while idle; with step unwritten, ready at decode
        prod_reg <= offset_reg * step_reg;
        if (cmd.capture)
        begin
            cmd_in_reg  <= s_tuser[0];
            kind_in_reg <= s_tuser[2:1];
            host_in_reg <= s_tdata[31:0];
            dev_in_reg  <= s_tdata[63:32];
            data_in_reg <= s_tdata[111:64];
        end
        if (cmd.pair_scale)
        begin
            host_scaled_reg <= host_scaled_next;
        end
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= {dh[WORD_W-1:0], {WORD_W{1'b0}}};
            dvs_reg <= dd;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_bit ? TICK_W'(div_trial - {1'b0, dvs_reg}) : div_trial[TICK_W-1:0];
            quo_reg <= {quo_reg[TICK_W-2:0], div_bit};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.stamp_add)
        begin
            devst_reg <= anchor_reg + TICK_W'(prod_reg);
        end
        if (cmd.stamp_diff)
        begin
            neg_reg <= diff[TICK_W-1];
            mag_reg <= diff[TICK_W-1] ? (~diff + 1'b1) : diff;
        end
        if (cmd.stamp_scale)
        begin
            part_reg <= scaled_prod[TICK_W-1:WORD_W];
        end
        if (cmd.out_load)
        begin
            out_stamp_reg <= stamp_next;
            if (kind_in_reg == KIND_ACCEL)
            begin
                out_kind_reg <= SAMPLE_MOTION;
                out_x_reg    <= data_in_reg[15:0];
                out_y_reg    <= data_in_reg[31:16];
                out_z_reg    <= data_in_reg[47:32];
                out_t_reg    <= '0;
            end
            else
            begin
                out_kind_reg <= SAMPLE_TEMP;
                out_x_reg    <= '0;
                out_y_reg    <= '0;
                out_z_reg    <= '0;
                out_t_reg    <= data_in_reg[15:0];
            end
        end
    end

    assign m_tdata = {out_t_reg, out_z_reg, out_y_reg, out_x_reg, out_stamp_reg};
    assign m_tuser = out_kind_reg;

endmodule
`default_nettype wire

[rtl/sftr_ctrl.sv]
`default_nettype none
module sftr_ctrl
    import sftr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.is_pair)
                begin
                    state_next = ST_PAIR_CHECK;
                end
                else if (sts.kind == KIND_TIMESTAMP || sts.kind == KIND_OTHER ||
                         !sts.anchor_valid)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_STAMP_DIFF;
                end
            end
            ST_PAIR_CHECK:  state_next = sts.div_ok ? ST_DIV : ST_IDLE;
            ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = ST_DIV_DONE;
                end
            end
            ST_DIV_DONE:    state_next = ST_IDLE;
            ST_STAMP_DIFF:  state_next = ST_STAMP_SCALE;
            ST_STAMP_SCALE: state_next = ST_STAMP_OUT;
            ST_STAMP_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:        state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_DECODE:
            begin
                cmd.pair_scale = sts.is_pair;
                cmd.set_anchor = !sts.is_pair && (sts.kind == KIND_TIMESTAMP);
                cmd.stamp_add  = !sts.is_pair;
            end
            ST_PAIR_CHECK:
            begin
                cmd.div_start  = sts.div_ok;
                cmd.pair_store = !sts.div_ok;
            end
            ST_DIV:         cmd.div_step = 1'b1;
            ST_DIV_DONE:
            begin
                cmd.ratio_update = 1'b1;
                cmd.pair_store   = 1'b1;
            end
            ST_STAMP_DIFF:  cmd.stamp_diff  = 1'b1;
            ST_STAMP_SCALE: cmd.stamp_scale = 1'b1;
            ST_STAMP_OUT:
            begin
                cmd.out_load   = out_free;
                cmd.offset_inc = out_free && (sts.kind == KIND_ACCEL);
            end
            default:        cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule
`default_nettype wire

[rtl/sensor_fifo_timestamp_rebuild.sv]
// Channel  | Direction | Payload
// ---------+-----------+-----------------------------------------------------
// s_axis   | in        | tdata: host_ticks, device_count, entry_data
//          |           | tuser: command, entry_kind
// m_axis   | out       | tdata: stamp, x_axis, y_axis, z_axis, temperature
//          |           | tuser: sample_kind
// cfg      | in        | cfg_we / cfg_index / cfg_data, write only
//
// One item is in flight at a time. A motion or temperature entry goes through
// decode with anchor add, pairing distance, ratio multiply and host add, where
// its result is loaded; the block then returns to idle for the next transfer.
// Timestamp and dropped entries return to idle straight after decode.
// A pairing ends after the pairing check, or after the divide and ratio update:
// the 32-bit restoring divider yields one quotient bit per cycle.
// rst_n resets the controller, the pairing/anchor state and the registers.
// A result held by m_tready low stalls only the next result-producing entry.
`default_nettype none
module sensor_fifo_timestamp_rebuild
    import sftr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // register write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    // input items
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,  // host_ticks[31:0], device_count[63:32],
                                                 // entry_data[111:64]
    input  wire logic [S_TUSER_W-1:0]  s_tuser,  // command[0], entry_kind[2:1]
    // result samples
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,  // stamp[31:0], x_axis[47:32], y_axis[63:48],
                                                 // z_axis[79:64], temperature[95:80]
    output logic [M_TUSER_W-1:0]       m_tuser   // sample_kind[0]
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencer: item decode, divide loop, stamp steps, output handshake
    sftr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // registers, pairing/anchor state, divider, stamp arithmetic, output reg
    sftr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire

[rtl/sftr_checker.sv]
`default_nettype none
module sftr_checker
    import sftr_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [M_TDATA_W-1:0]  m_tdata,
    input wire logic [M_TUSER_W-1:0]  m_tuser
);

    logic s_xfer;

    assign s_xfer = s_tvalid && s_tready;

    // one item at a time: no new transfer right after one is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer |=> !s_tready)
        else $error("input taken while previous item still in work");

    // a result needs the full stamp pipeline behind its transfer
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_xfer, 1) && !$past(s_xfer, 2) && !$past(s_xfer, 3))
        else $error("result appeared too soon after an input transfer");

    // unused fields of a sample are zero
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser[0] == SAMPLE_TEMP) ? (m_tdata[79:32] == '0)
                                                  : (m_tdata[95:80] == '0)))
        else $error("unused sample field not zero");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind sensor_fifo_timestamp_rebuild sftr_checker u_sftr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
